// ===== rtl/dit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intern table package
// Shared types, codes and constants of the intern table core.
// ----------------------------------------------------------------------------
package dit_pkg;

   // Default number of table entries.
   localparam int DEF_ENTRIES = 256;

   // Field widths.
   localparam int CAP_W      = 9;
   localparam int KIND_W     = 2;
   localparam int ID_W       = 32;
   localparam int KEY_W      = KIND_W + ID_W;
   localparam int INDEX_W    = 8;
   localparam int TOTAL_W    = 32;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   // Register indexes (word address bits of paddr).
   typedef enum logic [0:0] {
      CSR_IDX_CAPACITY = 1'b0
   } csr_idx_type;

   // Operation codes.
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INTERN = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_REJECT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_READ
   } state_type;

   // One command.
   typedef struct packed {
      op_type              op;
      logic                precheck_ok;
      logic [KIND_W-1:0]   kind;
      logic [ID_W-1:0]     object_id;
      logic [ID_W-1:0]     support_id;
      logic [INDEX_W-1:0]  index;
   } req_type;

   // One result.
   typedef struct packed {
      status_type          status;
      logic                found;
      logic [INDEX_W-1:0]  entry_index;
      logic [KIND_W-1:0]   entry_kind;
      logic [ID_W-1:0]     entry_object_id;
      logic [ID_W-1:0]     entry_support_id;
      logic [TOTAL_W-1:0]  request_total;
      logic [TOTAL_W-1:0]  hit_total;
   } rsp_type;

   // Address width of a memory of the given depth (at least one bit).
   function automatic int addr_width(input int depth);
      int w;
      w = (depth > 1) ? $clog2(depth) : 1;
      return w;
   endfunction

endpackage

// ===== rtl/dit_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dit_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [dit_pkg::addr_width(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [dit_pkg::addr_width(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   import dit_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dit_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intern table register block
// APB-style access to the capacity register.
// ----------------------------------------------------------------------------
module dit_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dit_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [dit_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [dit_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output logic [dit_pkg::CAP_W-1:0]         capacity
);
   import dit_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic             wr_hit;
   logic             sel_cap;

   // Register decode: the word address is the upper address bit.
   assign sel_cap = (paddr[CSR_ADDR_W-1] == CSR_IDX_CAPACITY);
   assign wr_hit  = psel && penable && pwrite && sel_cap;

   // Capacity takes the low bits of a completed write transfer.
   always_comb begin
      capacity_in = capacity_ff;
      if (wr_hit) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Read data and a ready that never waits.
   assign prdata   = sel_cap ? CSR_DATA_W'(capacity_ff) : '0;
   assign pready   = 1'b1;
   assign capacity = capacity_ff;

endmodule

// ===== rtl/dit_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intern table controller
// Sequences clear, intern, lookup and read over the key and claim memories.
// ----------------------------------------------------------------------------
module dit_ctrl #(
   parameter int ENTRIES = dit_pkg::DEF_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  dit_pkg::req_type           req_payload,
   output logic                       rsp_strobe,
   output dit_pkg::rsp_type           rsp_payload,
   input  logic [dit_pkg::CAP_W-1:0]  capacity
);
   import dit_pkg::*;

   localparam int AW = addr_width(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int XW = (CW > CAP_W) ? CW : CAP_W;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [CW-1:0]      live_ff, live_in;
   logic [TOTAL_W-1:0] reqcnt_ff, reqcnt_in;
   logic [TOTAL_W-1:0] hitcnt_ff, hitcnt_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr;
   logic [KEY_W-1:0]   rd_key, req_key;
   logic [ID_W-1:0]    rd_claim;

   logic               accept, match, scan_hit, scan_end, full, in_range;

   // Memories: one for the keys, one for the claims, sharing addresses.
   dit_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (live_ff[AW-1:0]),
      .wr_data (req_key),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_key)
   );

   dit_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_claim_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (live_ff[AW-1:0]),
      .wr_data (req_ff.support_id),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_claim)
   );

   // Status terms of the held command and the entry under compare.
   assign accept   = start && (state_ff == S_IDLE);
   assign req_key  = {req_ff.kind, req_ff.object_id};
   assign match    = (rd_key == req_key) &&
                     ((req_ff.op == OP_LOOKUP) || (rd_claim == req_ff.support_id));
   assign scan_hit = cmp_valid_ff && match;
   assign scan_end = (ptr_ff >= live_ff);
   assign full     = (XW'(live_ff) >= XW'(capacity)) || (XW'(live_ff) >= XW'(ENTRIES));
   assign in_range = (XW'(req_ff.index) < XW'(live_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (req_ff.op)
               OP_CLEAR: state_in = S_IDLE;
               OP_INTERN: state_in = req_ff.precheck_ok ? S_SCAN : S_IDLE;
               OP_LOOKUP: state_in = S_SCAN;
               OP_READ: state_in = in_range ? S_READ : S_IDLE;
               default: state_in = S_IDLE;
            endcase
         end
         S_SCAN: begin
            if (scan_hit || scan_end) begin
               state_in = S_IDLE;
            end
         end
         S_READ: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control per state.
   always_comb begin
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      live_in      = live_ff;
      reqcnt_in    = reqcnt_ff;
      hitcnt_in    = hitcnt_ff;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[AW-1:0];
      wr_en        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_payload;
            end
         end
         S_EXEC: begin
            ptr_in       = '0;
            cmp_valid_in = 1'b0;
            unique case (req_ff.op)
               OP_CLEAR: begin
                  live_in      = '0;
                  reqcnt_in    = '0;
                  hitcnt_in    = '0;
                  rsp_valid_in = 1'b1;
               end
               OP_INTERN: begin
                  if (req_ff.precheck_ok) begin
                     reqcnt_in = reqcnt_ff + 32'd1;
                  end else begin
                     rsp_in.status = ST_REJECT;
                     rsp_valid_in  = 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  // The scan starts in the next cycle.
               end
               OP_READ: begin
                  if (in_range) begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(req_ff.index);
                  end else begin
                     rsp_in.status = ST_REJECT;
                     rsp_valid_in  = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            if (scan_hit) begin
               // First matching entry ends the scan.
               rsp_in.found = 1'b1;
               rsp_valid_in = 1'b1;
               if (req_ff.op == OP_INTERN) begin
                  rsp_in.entry_index = INDEX_W'(cmp_idx_ff);
                  hitcnt_in          = hitcnt_ff + 32'd1;
               end
            end else if (scan_end) begin
               // All live entries compared without a match.
               rsp_valid_in = 1'b1;
               if (req_ff.op == OP_INTERN) begin
                  if (full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     rsp_in.entry_index = INDEX_W'(live_ff);
                     live_in            = live_ff + 1'b1;
                  end
               end
            end else begin
               // Issue the next read; its data is compared next cycle.
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = ptr_ff[AW-1:0];
               ptr_in       = ptr_ff + 1'b1;
            end
         end
         S_READ: begin
            rsp_in.entry_index      = req_ff.index;
            rsp_in.entry_kind       = rd_key[KEY_W-1:ID_W];
            rsp_in.entry_object_id  = rd_key[ID_W-1:0];
            rsp_in.entry_support_id = rd_claim;
            rsp_valid_in            = 1'b1;
         end
         default: begin
         end
      endcase
      rsp_in.request_total = reqcnt_in;
      rsp_in.hit_total     = hitcnt_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_valid_ff <= 1'b0;
         live_ff      <= '0;
         reqcnt_ff    <= '0;
         hitcnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         live_ff      <= live_in;
         reqcnt_ff    <= reqcnt_in;
         hitcnt_ff    <= hitcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      ptr_ff     <= ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/dedup_intern_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intern table core
// Append-only table of (kind, structural id, claim id) with linear search.
// ----------------------------------------------------------------------------
//   Channel   Ports                          Transfer when
//   command   start, busy, req_payload       start high and busy low
//   result    rsp_strobe, rsp_payload        rsp_strobe high (one cycle)
//   config    psel, penable, pwrite, paddr,  psel, penable, pready
//             pwdata, prdata, pready
//
// Clear, a rejected intern and a failed read give their result from the
// execute state; a read passes through the read state first. Intern and
// lookup compare one live entry per cycle through the registered memory read
// port and stop at the first hit or after the last live entry. Busy falls as
// the result is registered, so the next command may be taken in the cycle its
// result is shown. Reset is synchronous and needs no clearing pass; the
// receiver cannot stall results.
// ----------------------------------------------------------------------------
module dedup_intern_table_core #(
   parameter int ENTRIES = dit_pkg::DEF_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  dit_pkg::req_type                  req_payload,
   output logic                              rsp_strobe,
   output dit_pkg::rsp_type                  rsp_payload,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dit_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [dit_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [dit_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import dit_pkg::*;

   logic [CAP_W-1:0] capacity;

   // Configuration registers.
   dit_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   // Command sequencer with the table memories.
   dit_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .capacity    (capacity)
   );

   // A result only follows a cycle in which a command was in work.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a command in work");

   // Two results never come in consecutive cycles.
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results in consecutive cycles");

   // A taken command makes the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command transfer did not raise busy");

   // A hit is always reported with an ok status.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.found) |-> (rsp_payload.status == ST_OK))
      else $error("found with a failing status");

   // A full table gives no hit and no index.
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_payload.status == ST_FULL)) |->
      (!rsp_payload.found && (rsp_payload.entry_index == '0)))
      else $error("full result carries entry fields");

endmodule
